>>> hw/rtl/cda_pkg.sv
`default_nettype none

package cda_pkg;

    localparam int AMOUNT_BITS_DEF = 16;
    localparam int YEAR_BITS_DEF   = 16;

    // Command selector carried on the input tuser.
    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_DAYS   = 2'd1;
    localparam logic [1:0] KIND_MONTHS = 2'd2;
    localparam logic [1:0] KIND_YEARS  = 2'd3;

    // Result status carried on the output tuser.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_DATE = 2'd1;
    localparam logic [1:0] STAT_NEGATIVE = 2'd2;
    localparam logic [1:0] STAT_YEAR_OVF = 2'd3;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int DEFAULT_YEAR    = 1970;
    localparam int YEAR_CYCLE      = 400;
    localparam int CENTURY         = 100;

    localparam logic [3:0] JANUARY   = 4'd1;
    localparam logic [3:0] FEBRUARY  = 4'd2;
    localparam logic [3:0] MARCH     = 4'd3;
    localparam logic [3:0] APRIL     = 4'd4;
    localparam logic [3:0] JUNE      = 4'd6;
    localparam logic [3:0] SEPTEMBER = 4'd9;
    localparam logic [3:0] NOVEMBER  = 4'd11;
    localparam logic [3:0] DECEMBER  = 4'd12;

    localparam logic [4:0] FIRST_DAY = 5'd1;
    localparam logic [4:0] DAYS_28   = 5'd28;
    localparam logic [4:0] DAYS_29   = 5'd29;
    localparam logic [4:0] DAYS_30   = 5'd30;
    localparam logic [4:0] DAYS_31   = 5'd31;

    // Position of a year inside the 400-year Gregorian cycle.
    localparam logic [8:0] CYCLE_LEN     = 9'(YEAR_CYCLE);
    localparam logic [8:0] CYCLE_DEFAULT = 9'(DEFAULT_YEAR % YEAR_CYCLE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QDIV,
        ST_MADD,
        ST_YCHK,
        ST_YMOD,
        ST_YFIN,
        ST_WALK,
        ST_DONE
    } cda_state_t;

    typedef struct packed {
        logic start;
        logic by_cycle;
    } cda_div_req_t;

    typedef struct packed {
        logic done;
    } cda_div_rsp_t;

    // Leap test on the year's position in the 400-year cycle.
    function automatic logic is_leap(input logic [8:0] cyc);
        is_leap = (cyc[1:0] == 2'b00) && (cyc != 9'(CENTURY))
                  && (cyc != 9'(2 * CENTURY)) && (cyc != 9'(3 * CENTURY));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        case (month)
            FEBRUARY:                          month_len = leap ? DAYS_29 : DAYS_28;
            APRIL, JUNE, SEPTEMBER, NOVEMBER:  month_len = DAYS_30;
            default:                           month_len = DAYS_31;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cda_divser.sv
`default_nettype none

// Shared divider by a small constant (12 or 400), built on a reciprocal multiply.
// The operand is registered at the start, then the quotient, and then the
// remainder, which is ready when done pulses.
module cda_divser
    import cda_pkg::*;
#(
    parameter int WIDTH = YEAR_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cda_div_req_t     req,
    input  wire logic [WIDTH-1:0] operand,
    output cda_div_rsp_t          rsp,
    output logic [WIDTH-1:0]      quotient,
    output logic [8:0]            remainder
);

    // For any 32-bit x: x / 12 = (x * RECIP_12) >> 35 and x / 25 = (x * RECIP_25) >> 35.
    // A division by 400 drops the low four bits first and then divides by 25.
    localparam logic [31:0] RECIP_12    = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_25    = 32'h51EB_851F;
    localparam int          RECIP_SHIFT = 35;

    logic             q_pend_reg, q_pend_next;
    logic             r_pend_reg, r_pend_next;
    logic             done_reg, done_next;
    logic             by_cycle_reg, by_cycle_next;
    logic [WIDTH-1:0] op_reg, op_next;
    logic [WIDTH-1:0] quot_reg, quot_next;
    logic [8:0]       rem_reg, rem_next;

    logic [9:0]       divisor;
    logic [31:0]      op_ext;
    logic [31:0]      mul_in;
    logic [31:0]      recip;
    logic [63:0]      product;
    logic [19:0]      q_prod;
    logic [9:0]       rem_diff;

    always_comb begin
        divisor  = by_cycle_reg ? {1'b0, CYCLE_LEN} : 10'(MONTHS_PER_YEAR);
        op_ext   = 32'(op_reg);
        mul_in   = by_cycle_reg ? {4'b0000, op_ext[31:4]} : op_ext;
        recip    = by_cycle_reg ? RECIP_25 : RECIP_12;
        product  = 64'(mul_in) * 64'(recip);

        // The remainder is below 400, so ten low bits of the difference are exact.
        q_prod   = {10'd0, quot_reg[9:0]} * {10'd0, divisor};
        rem_diff = op_reg[9:0] - q_prod[9:0];

        q_pend_next   = req.start;
        r_pend_next   = q_pend_reg;
        done_next     = r_pend_reg;
        by_cycle_next = by_cycle_reg;
        op_next       = op_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;

        if (req.start) begin
            by_cycle_next = req.by_cycle;
            op_next       = operand;
        end
        if (q_pend_reg) begin
            quot_next = WIDTH'(product[63:RECIP_SHIFT]);
        end
        if (r_pend_reg) begin
            rem_next = rem_diff[8:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_pend_reg <= 1'b0;
            r_pend_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            q_pend_reg <= q_pend_next;
            r_pend_reg <= r_pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        by_cycle_reg <= by_cycle_next;
        op_reg       <= op_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
    end

    assign rsp.done  = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/calendar_date_arithmetic.sv
// Gregorian date register with set, add-days, add-months and add-years commands.
//
// Input channel (s_): one item is one command. s_tuser selects the command and
// s_tdata carries the amount and the fields of a new date. The block takes one
// item at a time: s_tready is high only while the block is idle.
// Output channel (m_): exactly one item per command, holding the date after the
// command, its leap flag and a status code on m_tuser. On any error the date
// shown is the one held before the command, and it is left unchanged.
//
// A command refused at once (negative amount to add-days or add-months, month
// above 12 or lowest year to set) and adding zero months go straight to the
// result. Set and add-years place the new year in the 400-year cycle through
// the shared constant divider, unless the year overflows first. Add-months
// divides the amount by 12 on that divider, adds the carry to the year, places
// it in the cycle and walks on past a day the new month lacks. Add-days walks
// one month per cycle. The next item is taken once the result is registered.
//
// Reset sets the date to 1 January 1970 and drops m_tvalid. The result sits in
// an output register; while the receiver stalls it holds, and the block may
// already take and work on the next item, waiting at the end until it is free.
`default_nettype none

module calendar_date_arithmetic
    import cda_pkg::*;
#(
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = YEAR_BITS_DEF,
    localparam int IN_W  = ((AMOUNT_BITS + 9 + YEAR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((YEAR_BITS + 10 + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // amount, new_day, new_month, new_year (from bit 0 up), zero padded
    input  wire logic [IN_W-1:0]  s_tdata,
    // kind
    input  wire logic [1:0]       s_tuser,

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // day_out, month_out, year_out, leap_out (from bit 0 up), zero padded
    output logic [OUT_W-1:0]      m_tdata,
    // status
    output logic [1:0]            m_tuser
);

    // Divider operand width, widened year sum width, day accumulator width.
    localparam int DV = (AMOUNT_BITS > YEAR_BITS) ? AMOUNT_BITS : YEAR_BITS;
    localparam int EW = DV + 2;
    localparam int DW = ((AMOUNT_BITS > 5) ? AMOUNT_BITS : 5) + 1;

    localparam int OFS_DAY   = AMOUNT_BITS;
    localparam int OFS_MONTH = AMOUNT_BITS + 5;
    localparam int OFS_YEAR  = AMOUNT_BITS + 9;

    localparam longint YEAR_MAX_L = (longint'(1) << (YEAR_BITS - 1)) - 1;
    localparam logic signed [EW-1:0]        Y_HI_W      = EW'(YEAR_MAX_L);
    localparam logic signed [EW-1:0]        Y_LO_W      = -Y_HI_W;
    localparam logic signed [YEAR_BITS-1:0] Y_HI        = YEAR_BITS'(YEAR_MAX_L);
    localparam logic signed [YEAR_BITS-1:0] Y_INVALID   = {1'b1, {(YEAR_BITS-1){1'b0}}};
    localparam logic signed [YEAR_BITS-1:0] Y_MINUS_ONE = '1;
    localparam logic signed [YEAR_BITS-1:0] Y_ONE       = YEAR_BITS'(1);
    localparam logic signed [YEAR_BITS-1:0] Y_DEFAULT   = YEAR_BITS'(DEFAULT_YEAR);

    // Input fields.
    logic signed [AMOUNT_BITS-1:0] in_amount;
    logic [4:0]                    in_day;
    logic [3:0]                    in_month;
    logic signed [YEAR_BITS-1:0]   in_year;

    assign in_amount = $signed(s_tdata[AMOUNT_BITS-1:0]);
    assign in_day    = s_tdata[OFS_DAY +: 5];
    assign in_month  = s_tdata[OFS_MONTH +: 4];
    assign in_year   = $signed(s_tdata[OFS_YEAR +: YEAR_BITS]);

    // Architectural date, including its place in the 400-year cycle.
    logic [4:0]                  day_reg, day_next;
    logic [3:0]                  month_reg, month_next;
    logic signed [YEAR_BITS-1:0] year_reg, year_next;
    logic [8:0]                  cyc_reg, cyc_next;

    cda_state_t                  state_reg, state_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [1:0]                  status_reg, status_next;

    // Working copy of the date while a command is in progress.
    logic [DW-1:0]               wday_reg, wday_next;
    logic [3:0]                  wmon_reg, wmon_next;
    logic signed [YEAR_BITS-1:0] wyear_reg, wyear_next;
    logic [8:0]                  wcyc_reg, wcyc_next;
    logic signed [EW-1:0]        ywide_reg, ywide_next;

    logic                        m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]            m_data_reg, m_data_next;
    logic [1:0]                  m_user_reg, m_user_next;

    // Shared divider.
    cda_div_req_t                div_req;
    cda_div_rsp_t                div_rsp;
    logic [DV-1:0]               div_operand;
    logic [DV-1:0]               div_quot;
    logic [8:0]                  div_rem;

    cda_divser #(
        .WIDTH (DV)
    ) u_divser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .operand   (div_operand),
        .rsp       (div_rsp),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Datapath terms.
    logic [4:0]                  set_day;
    logic [3:0]                  set_month;
    logic signed [YEAR_BITS-1:0] set_year;
    logic signed [EW-1:0]        year_sum;
    logic [4:0]                  month_sum;
    logic                        month_over;
    logic signed [EW-1:0]        carry_sum0, carry_sum1;
    logic [YEAR_BITS-1:0]        yw_mag;
    logic [8:0]                  cyc_fold;
    logic [4:0]                  walk_len;
    logic                        walk_more;
    logic                        wyear_at_minus_one;
    logic [8:0]                  cyc_raw, cyc_step;

    always_comb begin
        set_day    = (in_day == 5'd0) ? FIRST_DAY : in_day;
        set_month  = (in_month == 4'd0) ? JANUARY : in_month;
        set_year   = (in_year == '0) ? Y_DEFAULT : in_year;

        year_sum   = EW'(year_reg) + EW'(in_amount);

        month_sum  = {1'b0, month_reg} + {1'b0, div_rem[3:0]};
        month_over = (month_sum > 5'(MONTHS_PER_YEAR));

        // Year plus carried years; one more when the sum crosses over year 0.
        carry_sum0 = EW'(year_reg) + ywide_reg;
        carry_sum1 = EW'(year_reg) + ywide_reg + EW'(1);

        yw_mag     = ywide_reg[EW-1] ? YEAR_BITS'(-ywide_reg) : ywide_reg[YEAR_BITS-1:0];

        // The divider works on the magnitude; fold back for negative years.
        cyc_fold   = (wyear_reg[YEAR_BITS-1] && (div_rem != 9'd0)) ? (CYCLE_LEN - div_rem)
                                                                    : div_rem;

        walk_len   = month_len(wmon_reg, is_leap(wcyc_reg));
        walk_more  = (wday_reg > DW'(walk_len));

        // Year -1 is followed by year 1.
        wyear_at_minus_one = (wyear_reg == Y_MINUS_ONE);
        cyc_raw    = wcyc_reg + (wyear_at_minus_one ? 9'd2 : 9'd1);
        cyc_step   = (cyc_raw >= CYCLE_LEN) ? (cyc_raw - CYCLE_LEN) : cyc_raw;
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        status_next  = status_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        cyc_next     = cyc_reg;
        wday_next    = wday_reg;
        wmon_next    = wmon_reg;
        wyear_next   = wyear_reg;
        wcyc_next    = wcyc_reg;
        ywide_next   = ywide_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;

        div_req      = '0;
        div_operand  = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    status_next = STAT_OK;
                    case (s_tuser)
                        KIND_SET: begin
                            wday_next  = DW'(set_day);
                            wmon_next  = set_month;
                            ywide_next = EW'(set_year);
                            if ((set_month > 4'(MONTHS_PER_YEAR)) || (set_year == Y_INVALID)) begin
                                status_next = STAT_BAD_DATE;
                                state_next  = ST_DONE;
                            end else begin
                                state_next  = ST_YCHK;
                            end
                        end
                        KIND_DAYS: begin
                            if (in_amount[AMOUNT_BITS-1]) begin
                                status_next = STAT_NEGATIVE;
                                state_next  = ST_DONE;
                            end else begin
                                wday_next  = DW'(day_reg) + DW'($unsigned(in_amount));
                                wmon_next  = month_reg;
                                wyear_next = year_reg;
                                wcyc_next  = cyc_reg;
                                state_next = ST_WALK;
                            end
                        end
                        KIND_MONTHS: begin
                            if (in_amount[AMOUNT_BITS-1]) begin
                                status_next = STAT_NEGATIVE;
                                state_next  = ST_DONE;
                            end else if (in_amount == '0) begin
                                state_next  = ST_DONE;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.by_cycle = 1'b0;
                                div_operand      = DV'($unsigned(in_amount));
                                state_next       = ST_QDIV;
                            end
                        end
                        default: begin
                            // Adding years: a landing on year 0 moves one more step on.
                            if (year_sum == '0) begin
                                ywide_next = in_amount[AMOUNT_BITS-1] ? -EW'(1) : EW'(1);
                            end else begin
                                ywide_next = year_sum;
                            end
                            state_next = ST_YCHK;
                        end
                    endcase
                end
            end

            ST_QDIV: begin
                if (div_rsp.done) begin
                    wmon_next  = month_over ? 4'(month_sum - 5'(MONTHS_PER_YEAR))
                                            : month_sum[3:0];
                    ywide_next = EW'($unsigned(div_quot)) + EW'(month_over);
                    wday_next  = DW'(day_reg);
                    state_next = ST_MADD;
                end
            end

            ST_MADD: begin
                if (year_reg[YEAR_BITS-1] && !carry_sum0[EW-1]) begin
                    ywide_next = carry_sum1;
                end else begin
                    ywide_next = carry_sum0;
                end
                state_next = ST_YCHK;
            end

            ST_YCHK: begin
                if ((ywide_reg > Y_HI_W) || (ywide_reg < Y_LO_W)) begin
                    status_next = STAT_YEAR_OVF;
                    state_next  = ST_DONE;
                end else begin
                    wyear_next       = ywide_reg[YEAR_BITS-1:0];
                    div_req.start    = 1'b1;
                    div_req.by_cycle = 1'b1;
                    div_operand      = DV'(yw_mag);
                    state_next       = ST_YMOD;
                end
            end

            ST_YMOD: begin
                if (div_rsp.done) begin
                    wcyc_next  = cyc_fold;
                    state_next = ST_YFIN;
                end
            end

            ST_YFIN: begin
                state_next = ST_DONE;
                case (kind_reg)
                    KIND_SET: begin
                        if (walk_more) begin
                            status_next = STAT_BAD_DATE;
                        end else begin
                            day_next   = wday_reg[4:0];
                            month_next = wmon_reg;
                            year_next  = wyear_reg;
                            cyc_next   = wcyc_reg;
                        end
                    end
                    KIND_MONTHS: begin
                        state_next = ST_WALK;
                    end
                    KIND_YEARS: begin
                        year_next = wyear_reg;
                        cyc_next  = wcyc_reg;
                        // The leap day of a year that has none becomes 1 March.
                        if ((day_reg == DAYS_29) && (month_reg == FEBRUARY)
                            && !is_leap(wcyc_reg)) begin
                            day_next   = FIRST_DAY;
                            month_next = MARCH;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_WALK: begin
                if (walk_more) begin
                    wday_next = wday_reg - DW'(walk_len);
                    if (wmon_reg == DECEMBER) begin
                        if (wyear_reg == Y_HI) begin
                            status_next = STAT_YEAR_OVF;
                            state_next  = ST_DONE;
                        end else begin
                            wmon_next  = JANUARY;
                            wyear_next = wyear_at_minus_one ? Y_ONE : (wyear_reg + Y_ONE);
                            wcyc_next  = cyc_step;
                        end
                    end else begin
                        wmon_next = wmon_reg + 4'd1;
                    end
                end else begin
                    day_next   = wday_reg[4:0];
                    month_next = wmon_reg;
                    year_next  = wyear_reg;
                    cyc_next   = wcyc_reg;
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({is_leap(cyc_reg), year_reg, month_reg, day_reg});
                    m_user_next  = status_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            day_reg     <= FIRST_DAY;
            month_reg   <= JANUARY;
            year_reg    <= Y_DEFAULT;
            cyc_reg     <= CYCLE_DEFAULT;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            cyc_reg     <= cyc_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        wday_reg   <= wday_next;
        wmon_reg   <= wmon_next;
        wyear_reg  <= wyear_next;
        wcyc_reg   <= wcyc_next;
        ywide_reg  <= ywide_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

>>> hw/rtl/cda_checker.sv
`default_nettype none

module cda_checker
    import cda_pkg::*;
#(
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = YEAR_BITS_DEF,
    localparam int IN_W  = ((AMOUNT_BITS + 9 + YEAR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((YEAR_BITS + 10 + 7) / 8) * 8
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic [IN_W-1:0]  s_tdata,
    input wire logic [1:0]       s_tuser,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [1:0]       m_tuser
);

    logic [4:0] m_day;
    logic [3:0] m_month;
    logic       m_leap;

    assign m_day   = m_tdata[4:0];
    assign m_month = m_tdata[8:5];
    assign m_leap  = m_tdata[YEAR_BITS + 9];

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One command at a time: the block is busy right after taking an item.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser) |=> !s_tready)
        else $error("item taken while a command was in progress");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_month >= JANUARY) && (m_month <= DECEMBER) && (m_day >= FIRST_DAY))
        else $error("month or day out of range");

    // The day shown must exist in the month and year shown.
    a_day_fits_month: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_month != FEBRUARY) || (m_day <= DAYS_28) || (m_day == DAYS_29 && m_leap))
            && ((m_month != APRIL && m_month != JUNE && m_month != SEPTEMBER
                 && m_month != NOVEMBER) || (m_day <= DAYS_30)))
        else $error("day does not exist in its month");

endmodule

bind calendar_date_arithmetic cda_checker #(
    .AMOUNT_BITS (AMOUNT_BITS),
    .YEAR_BITS   (YEAR_BITS)
) u_cda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
